/* rtl/core/contrast_modulated_grating_pixel_assert.svh */
// ----------------------------------------------------------------------------
// Contrast-modulated grating pixel: assertion macros
// Immediate-consequence and next-cycle checks on the block clock and reset.
// ----------------------------------------------------------------------------
`ifndef CONTRAST_MODULATED_GRATING_PIXEL_ASSERT_SVH
`define CONTRAST_MODULATED_GRATING_PIXEL_ASSERT_SVH

// cons holds in the same cycle as ante
`define CMG_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("cmg: same-cycle check failed");

// cons holds in the cycle after ante
`define CMG_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("cmg: next-cycle check failed");

`endif

/* rtl/core/cmg_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cmg_pkg
// Shared constants, register indexes and pipeline control type.
// ----------------------------------------------------------------------------
package cmg_pkg;

  localparam int NSTG = 14;

  localparam logic [15:0] SIN_A = 16'd51472;
  localparam logic [15:0] SIN_B = 16'd21024;
  localparam logic [15:0] SIN_C = 16'd2320;
  localparam logic [15:0] HALF_Q15 = 16'd32768;
  localparam logic [15:0] QUARTER_TURN = 16'd16384;

  localparam logic signed [10:0] MAX_HALF_WIDTH = 11'sd1023;
  localparam logic [16:0] LUM_MAX = 17'd131071;
  localparam logic [15:0] CONTRAST_RST = 16'd16384;
  localparam logic signed [18:0] UNITY_Q15 = 19'sd32768;
  localparam logic signed [17:0] ENV_OFFSET = 18'sd32768;

  typedef enum logic [2:0] {
    REG_CARRIER_ANGLE  = 3'd0,
    REG_CARRIER_FREQ   = 3'd1,
    REG_CARRIER_PHASE  = 3'd2,
    REG_ENVELOPE_ANGLE = 3'd3,
    REG_ENVELOPE_FREQ  = 3'd4,
    REG_ENVELOPE_PHASE = 3'd5,
    REG_CONTRAST       = 3'd6,
    REG_MEAN_LUM       = 3'd7
  } cfg_reg_t;

  typedef struct packed {
    logic            en;
    logic [NSTG-1:0] vld;
    logic            out_vld;
    logic            out_load;
    logic            out_from_skid;
    logic            skid_load;
  } flow_t;

endpackage

/* rtl/core/contrast_modulated_grating_pixel.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// contrast_modulated_grating_pixel
// Luminance of one pixel of a contrast-modulated (second-order) grating.
// ----------------------------------------------------------------------------
// Input channel: in_valid / in_stall carry one word of x_offset, y_offset
// (signed offsets from the image centre, clamped to +-1023).
// Output channel: out_valid / out_stall carry one word of luminance.
// Registers are written through cfg_we / cfg_idx / cfg_data; the user must
// write them only while the block holds no word in flight, which the block
// itself does not enforce. Throughput: one word per clock while in_stall is
// low. An accepted word passes the offset delay, rotation, phase, carrier and
// envelope sine (four-stage) and modulation stages on its way to out_valid.
// A stalled output word holds; the next finished word parks in a skid
// register, and only while that is full does in_stall rise, so the input
// side keeps flowing while one result waits.
// Reset clears all valid flags and loads the register defaults (contrast
// 0.5, everything else zero); no word is in flight afterwards.
// ----------------------------------------------------------------------------
module contrast_modulated_grating_pixel import cmg_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_idx,
  input  logic [15:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [10:0] x_offset,
  input  logic signed [10:0] y_offset,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [16:0]        luminance
);

  flow_t flow;

  logic [15:0] carrier_angle;
  logic [15:0] carrier_freq;
  logic [15:0] carrier_phase;
  logic [15:0] envelope_angle;
  logic [15:0] envelope_freq;
  logic [15:0] envelope_phase;
  logic [15:0] contrast;
  logic [15:0] mean_lum;

  logic signed [10:0] xc;
  logic signed [10:0] yc;
  logic signed [10:0] xs [4];
  logic signed [10:0] ys [4];

  logic signed [16:0] c_cos;
  logic signed [16:0] c_sin;
  logic signed [16:0] e_cos;
  logic signed [16:0] e_sin;

  logic signed [27:0] pcx;
  logic signed [27:0] pcy;
  logic signed [27:0] pex;
  logic signed [27:0] pey;
  logic signed [28:0] xr_c;
  logic signed [28:0] xr_e;
  logic signed [45:0] mc;
  logic signed [45:0] me;
  logic [15:0]        ph_c;
  logic [15:0]        ph_e;

  logic signed [16:0] car;
  logic signed [16:0] cos_e;
  logic signed [17:0] env_sum;
  logic signed [16:0] env;
  logic signed [33:0] mprod;
  logic signed [16:0] m;
  logic signed [33:0] cprod;
  logic signed [17:0] cm;
  logic signed [18:0] fac;
  logic [32:0]        lprod;
  logic               pos;
  logic [17:0]        lsh;
  logic [16:0]        lum_new;
  logic [16:0]        skid_lum;

  // register file
  always_ff @(posedge clk) begin
    if (rst) begin
      carrier_angle  <= '0;
      carrier_freq   <= '0;
      carrier_phase  <= '0;
      envelope_angle <= '0;
      envelope_freq  <= '0;
      envelope_phase <= '0;
      contrast       <= CONTRAST_RST;
      mean_lum       <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_CARRIER_ANGLE:  carrier_angle  <= cfg_data;
        REG_CARRIER_FREQ:   carrier_freq   <= cfg_data;
        REG_CARRIER_PHASE:  carrier_phase  <= cfg_data;
        REG_ENVELOPE_ANGLE: envelope_angle <= cfg_data;
        REG_ENVELOPE_FREQ:  envelope_freq  <= cfg_data;
        REG_ENVELOPE_PHASE: envelope_phase <= cfg_data;
        REG_CONTRAST:       contrast       <= cfg_data;
        REG_MEAN_LUM:       mean_lum       <= cfg_data;
        default: ;
      endcase
    end
  end

  cmg_flow u_flow (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .out_stall (out_stall),
    .flow      (flow)
  );

  assign in_stall  = !flow.en;
  assign out_valid = flow.out_vld;

  always_comb begin
    if (x_offset > MAX_HALF_WIDTH) begin
      xc = MAX_HALF_WIDTH;
    end else if (x_offset < -MAX_HALF_WIDTH) begin
      xc = -MAX_HALF_WIDTH;
    end else begin
      xc = x_offset;
    end
    if (y_offset > MAX_HALF_WIDTH) begin
      yc = MAX_HALF_WIDTH;
    end else if (y_offset < -MAX_HALF_WIDTH) begin
      yc = -MAX_HALF_WIDTH;
    end else begin
      yc = y_offset;
    end
  end

  // stages 0-3: rotation sines and cosines
  cmg_sin u_ccos (.clk(clk), .en(flow.en), .angle(carrier_angle + QUARTER_TURN),
                  .value(c_cos));
  cmg_sin u_csin (.clk(clk), .en(flow.en), .angle(carrier_angle), .value(c_sin));
  cmg_sin u_ecos (.clk(clk), .en(flow.en), .angle(envelope_angle + QUARTER_TURN),
                  .value(e_cos));
  cmg_sin u_esin (.clk(clk), .en(flow.en), .angle(envelope_angle), .value(e_sin));

  // stages 7-10: carrier and envelope cosines
  cmg_sin u_car (.clk(clk), .en(flow.en), .angle(ph_c + QUARTER_TURN), .value(car));
  cmg_sin u_env (.clk(clk), .en(flow.en), .angle(ph_e + QUARTER_TURN), .value(cos_e));

  assign mc      = 46'(xr_c) * 46'($signed({1'b0, carrier_freq}));
  assign me      = 46'(xr_e) * 46'($signed({1'b0, envelope_freq}));
  assign env_sum = 18'(cos_e) + ENV_OFFSET;
  assign env     = $signed(env_sum[17:1]);
  assign mprod   = 34'(car) * 34'(env);
  assign cprod   = 34'($signed({1'b0, contrast})) * 34'(m);
  assign fac     = UNITY_Q15 + 19'(cm);
  assign lsh     = lprod[32:15];

  always_comb begin
    if (!pos) begin
      lum_new = '0;
    end else if (lsh > 18'(LUM_MAX)) begin
      lum_new = LUM_MAX;
    end else begin
      lum_new = lsh[16:0];
    end
  end

  always_ff @(posedge clk) begin
    if (flow.en) begin
      xs[0] <= xc;
      ys[0] <= yc;
      for (int i = 1; i < 4; i++) begin
        xs[i] <= xs[i-1];
        ys[i] <= ys[i-1];
      end
      pcx   <= 28'(c_cos) * 28'(xs[3]);
      pcy   <= 28'(c_sin) * 28'(ys[3]);
      pex   <= 28'(e_cos) * 28'(xs[3]);
      pey   <= 28'(e_sin) * 28'(ys[3]);
      xr_c  <= 29'(pcx) + 29'(pcy);
      xr_e  <= 29'(pex) + 29'(pey);
      ph_c  <= mc[30:15] + carrier_phase;
      ph_e  <= me[30:15] + envelope_phase;
      m     <= mprod[31:15];
      cm    <= cprod[32:15];
      pos   <= fac > 19'sd0;
      lprod <= 33'(mean_lum) * 33'(fac[16:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (flow.out_load) begin
      luminance <= flow.out_from_skid ? skid_lum : lum_new;
    end
    if (flow.skid_load) begin
      skid_lum <= lum_new;
    end
  end

`include "contrast_modulated_grating_pixel_assert.svh"

  `CMG_ASSERT_NOW(a_stall_has_out, in_stall, out_valid)
  `CMG_ASSERT_NEXT(a_accept_enters, in_valid && !in_stall, flow.vld[0])
  `CMG_ASSERT_NEXT(a_skid_drains, in_stall && !out_stall, !in_stall)
  `CMG_ASSERT_NEXT(a_skid_fills, flow.vld[NSTG-1] && flow.en && out_valid && out_stall,
                   in_stall)

endmodule

/* rtl/core/cmg_sin.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cmg_sin
// Four-stage Q15 sine of a 16-bit turn angle, quarter-wave polynomial.
// ----------------------------------------------------------------------------
module cmg_sin import cmg_pkg::*; (
  input  logic               clk,
  input  logic               en,
  input  logic [15:0]        angle,
  output logic signed [16:0] value
);

  logic        neg [3];
  logic [15:0] arg [3];
  logic [15:0] sq  [2];
  logic [15:0] t1;
  logic [15:0] t2;
  logic [15:0] fold;
  logic [15:0] u;
  logic [15:0] w;
  logic [31:0] p_sq;
  logic [31:0] p_t1;
  logic [31:0] p_t2;
  logic [31:0] p_s;

  always_comb begin
    fold = {1'b0, angle[13:0], 1'b0};
    if (angle[14]) begin
      fold = HALF_Q15 - fold;
    end
  end

  assign p_sq = 32'(fold) * 32'(fold);
  assign p_t1 = 32'(SIN_C) * 32'(sq[0]);
  assign u    = SIN_B - t1;
  assign p_t2 = 32'(u) * 32'(sq[1]);
  assign w    = SIN_A - t2;
  assign p_s  = 32'(w) * 32'(arg[2]);

  always_ff @(posedge clk) begin
    if (en) begin
      neg[0] <= angle[15];
      arg[0] <= fold;
      sq[0]  <= p_sq[30:15];
      neg[1] <= neg[0];
      arg[1] <= arg[0];
      sq[1]  <= sq[0];
      t1     <= p_t1[30:15];
      neg[2] <= neg[1];
      arg[2] <= arg[1];
      t2     <= p_t2[30:15];
      value  <= neg[2] ? -$signed({1'b0, p_s[30:15]}) : $signed({1'b0, p_s[30:15]});
    end
  end

endmodule

/* rtl/core/cmg_flow.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cmg_flow
// Valid pipeline, output register and skid word control.
// ----------------------------------------------------------------------------
module cmg_flow import cmg_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  input  logic  out_stall,
  output flow_t flow
);

  logic [NSTG-1:0] vld;
  logic            out_vld;
  logic            skid_vld;
  logic            en;
  logic            new_vld;
  logic            out_free;

  assign en       = !skid_vld;
  assign new_vld  = vld[NSTG-1] && en;
  assign out_free = !out_vld || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld      <= '0;
      out_vld  <= 1'b0;
      skid_vld <= 1'b0;
    end else begin
      if (en) begin
        vld <= {vld[NSTG-2:0], in_valid};
      end
      if (out_free) begin
        out_vld  <= skid_vld || new_vld;
        skid_vld <= 1'b0;
      end else if (new_vld) begin
        skid_vld <= 1'b1;
      end
    end
  end

  always_comb begin
    flow.en            = en;
    flow.vld           = vld;
    flow.out_vld       = out_vld;
    flow.out_load      = out_free;
    flow.out_from_skid = skid_vld;
    flow.skid_load     = !out_free && new_vld;
  end

endmodule
